// ===== rtl/atlg_pkg.sv =====
// Package for the axis tick label generator: widths, job struct, state enum, powers of ten.
// No dependencies.
package atlg_pkg;
  localparam int unsigned ValueBits  = 48;
  localparam int unsigned OutBits    = 50;
  localparam int unsigned FracDigits = 6;
  localparam int unsigned TicksLo    = 2;
  localparam int unsigned TicksHi    = 40;
  localparam int unsigned MaxTicks   = 62;
  localparam int unsigned Pow10Max   = 15;

  localparam logic [2:0] RegTickCount = 3'd0;

  typedef logic signed [ValueBits-1:0] val_t;
  typedef logic [OutBits-1:0] uval_t;

  // one classified range request handed from front to back
  typedef struct packed {
    logic  bad;
    val_t  mn;
    val_t  mx;
    logic [5:0] m;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE, B_SPAN, B_RANGE, B_DIV, B_NICE, B_LOG, B_GMIN, B_GMAX, B_EMIT
  } back_state_e;

  // powers of ten up to 10^15, looked up
  function automatic uval_t pow10(input logic [3:0] e);
    uval_t p;
    unique case (e)
      4'd0:  p = 50'd1;
      4'd1:  p = 50'd10;
      4'd2:  p = 50'd100;
      4'd3:  p = 50'd1000;
      4'd4:  p = 50'd10000;
      4'd5:  p = 50'd100000;
      4'd6:  p = 50'd1000000;
      4'd7:  p = 50'd10000000;
      4'd8:  p = 50'd100000000;
      4'd9:  p = 50'd1000000000;
      4'd10: p = 50'd10000000000;
      4'd11: p = 50'd100000000000;
      4'd12: p = 50'd1000000000000;
      4'd13: p = 50'd10000000000000;
      4'd14: p = 50'd100000000000000;
      4'd15: p = 50'd1000000000000000;
    endcase
    return p;
  endfunction
endpackage

// ===== rtl/atlg_front.sv =====
// Front part: accepts range items, saturates tick count, flags empty ranges.
// Depends on atlg_pkg.
module atlg_front import atlg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_stall,
  input  val_t       data_min_i,
  input  val_t       data_max_i,
  input  logic [5:0] tick_count_i,
  output logic       job_valid_o,
  output job_t       job_o,
  input  logic       job_pop_i
);
  // two-entry queue
  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;
  logic [5:0] n;
  job_t       nj;

  assign in_stall = (cnt_q == 2'd2);
  assign push     = in_valid && !in_stall;

  // classify
  always_comb begin
    n = tick_count_i;
    if (n < 6'(TicksLo)) n = 6'(TicksLo);
    if (n > 6'(TicksHi)) n = 6'(TicksHi);
    nj.bad = (data_max_i <= data_min_i);
    nj.mn  = data_min_i;
    nj.mx  = data_max_i;
    nj.m   = n - 6'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= nj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (job_pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(job_pop_i);
    end
  end

  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = mem_q[rp_q];
endmodule

// ===== rtl/atlg_divider.sv =====
// Shared restoring divider: 51-bit unsigned dividend by 51-bit divisor, one bit a cycle.
// Depends on atlg_pkg.
module atlg_divider import atlg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [50:0] num_i,
  input  logic [50:0] den_i,
  output logic        done_o,
  output logic [50:0] quo_o,
  output logic [50:0] rem_o
);
  logic [50:0] quo_q, rem_q, den_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [51:0] trial;

  assign trial = {rem_q, quo_q[50]} - {1'b0, den_q};

  // shift one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_o <= 1'b0;
      quo_q <= '0; rem_q <= '0; den_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; cnt_q <= 6'd51;
        quo_q <= num_i; rem_q <= '0; den_q <= den_i;
      end else if (busy_q) begin
        if (!trial[51]) begin
          rem_q <= trial[50:0];
          quo_q <= {quo_q[49:0], 1'b1};
        end else begin
          rem_q <= {rem_q[49:0], quo_q[50]};
          quo_q <= {quo_q[49:0], 1'b0};
        end
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0; done_o <= 1'b1;
        end
      end
    end
  end

  assign quo_o = quo_q;
  assign rem_o = rem_q;
endmodule

// ===== rtl/atlg_back.sv =====
// Back part: nice span and spacing, grid ends, tick emission with output register.
// Depends on atlg_pkg and atlg_divider.
module atlg_back import atlg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_pop_o,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [OutBits-1:0] tick_value_o,
  output uval_t       tick_spacing_o,
  output logic [2:0]  frac_digits_o,
  output logic        is_last_o,
  output logic        bad_range_o
);
  back_state_e st_q, st_d;
  job_t        job_q;
  uval_t       span_q, q_q, d_q;
  logic [5:0]  r_q;
  logic [3:0]  e_q;
  logic [2:0]  nfrac_q;
  logic signed [50:0] v_q, gmax_q;
  logic [5:0]  cnt_q;
  logic        ovalid_q;
  logic        load;
  logic        div_start;
  logic [50:0] div_num, div_den, quo, rem;
  logic        div_done;
  uval_t       p, nice_range;
  logic [51:0] tq, p_ext;
  logic signed [50:0] dd, rem_s, mn_s, mx_s, grid_lo, grid_hi;
  logic [50:0] absv;

  atlg_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(quo), .rem_o(rem)
  );

  assign load  = !ovalid_q || !out_stall;
  assign p     = pow10(e_q);
  assign p_ext = 52'(p);
  assign dd    = 51'(d_q);
  assign tq    = {1'b0, q_q, 1'b0} + 52'({r_q, 1'b0} >= {1'b0, job_q.m});
  assign rem_s = $signed(rem);
  assign mn_s  = {{3{job_q.mn[ValueBits-1]}}, job_q.mn};
  assign mx_s  = {{3{job_q.mx[ValueBits-1]}}, job_q.mx};

  // round the span up to 1, 2, 5 or 10 times its decade
  always_comb begin
    if (span_q <= p) nice_range = p;
    else if (span_q <= uval_t'(2) * p) nice_range = uval_t'(2) * p;
    else if (span_q <= uval_t'(5) * p) nice_range = uval_t'(5) * p;
    else nice_range = uval_t'(10) * p;
  end

  // grid ends from the remainder of |x| / d: floor for min, ceil for max
  assign grid_lo = job_q.mn[ValueBits-1] ? mn_s + rem_s - ((rem != '0) ? dd : 51'sd0)
                                         : mn_s - rem_s;
  assign grid_hi = job_q.mx[ValueBits-1] ? mx_s + rem_s
                                         : mx_s - rem_s + ((rem != '0) ? dd : 51'sd0);

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      B_IDLE:  if (job_valid_i) st_d = B_SPAN;
      B_SPAN:  st_d = job_q.bad ? B_EMIT : (e_q == 4'(Pow10Max) ||
                 pow10(e_q + 4'd1) > span_q) ? B_RANGE : B_SPAN;
      B_RANGE: st_d = B_DIV;
      B_DIV:   if (div_done) st_d = B_NICE;
      B_NICE:  if (q_q == '0 || e_q == 4'(Pow10Max) || pow10(e_q + 4'd1) > q_q)
                 st_d = B_LOG;
      B_LOG:   if (e_q == 4'(Pow10Max) || pow10(e_q + 4'd1) > d_q) st_d = B_GMIN;
      B_GMIN:  if (div_done) st_d = B_GMAX;
      B_GMAX:  if (div_done) st_d = B_EMIT;
      B_EMIT:  if (load && (job_q.bad || v_q == gmax_q || cnt_q == 6'(MaxTicks - 1)))
                 st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  // divider controls
  always_comb begin
    job_pop_o = (st_q == B_IDLE) && job_valid_i;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    absv      = '0;
    unique case (st_q)
      B_RANGE: begin
        div_start = 1'b1; div_num = 51'(nice_range); div_den = 51'(job_q.m);
      end
      B_LOG: if (st_d == B_GMIN) begin
        absv = job_q.mn[ValueBits-1] ? 51'(-mn_s) : 51'(mn_s);
        div_start = 1'b1; div_num = absv; div_den = 51'(d_q);
      end
      B_GMIN: if (div_done) begin
        absv = job_q.mx[ValueBits-1] ? 51'(-mx_s) : 51'(mx_s);
        div_start = 1'b1; div_num = absv; div_den = 51'(d_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE; ovalid_q <= 1'b0; cnt_q <= '0;
      job_q <= '0; span_q <= '0; q_q <= '0; d_q <= '0; r_q <= '0; e_q <= '0;
      nfrac_q <= '0; v_q <= '0; gmax_q <= '0;
      tick_value_o <= '0; tick_spacing_o <= '0; frac_digits_o <= '0;
      is_last_o <= 1'b0; bad_range_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load) ovalid_q <= (st_q == B_EMIT);
      unique case (st_q)
        B_IDLE: if (job_valid_i) begin
          job_q <= job_i; e_q <= '0; cnt_q <= '0;
          span_q <= uval_t'({{3{job_i.mx[ValueBits-1]}}, job_i.mx} -
                            {{3{job_i.mn[ValueBits-1]}}, job_i.mn});
        end
        B_SPAN: if (st_d == B_SPAN) e_q <= e_q + 4'd1;
        B_DIV: if (div_done) begin
          q_q <= uval_t'(quo); r_q <= rem[5:0]; e_q <= '0;
        end
        B_NICE: if (st_d == B_LOG) begin
          e_q <= '0;
          if (q_q == '0) d_q <= uval_t'(1);
          else if (tq < 52'd3 * p_ext) d_q <= p;
          else if (tq < 52'd6 * p_ext) d_q <= uval_t'(2) * p;
          else if (tq < 52'd14 * p_ext) d_q <= uval_t'(5) * p;
          else d_q <= uval_t'(10) * p;
        end else e_q <= e_q + 4'd1;
        B_LOG: if (st_d == B_GMIN) begin
          nfrac_q <= (e_q >= 4'(FracDigits)) ? 3'd0 : 3'(4'(FracDigits) - e_q);
        end else e_q <= e_q + 4'd1;
        B_GMIN: if (div_done) v_q <= grid_lo;
        B_GMAX: if (div_done) gmax_q <= grid_hi;
        B_EMIT: if (load) begin
          bad_range_o <= job_q.bad;
          if (job_q.bad) begin
            tick_value_o <= '0; tick_spacing_o <= '0; frac_digits_o <= '0;
            is_last_o <= 1'b1;
          end else begin
            tick_value_o <= v_q[OutBits-1:0]; tick_spacing_o <= d_q;
            frac_digits_o <= nfrac_q;
            is_last_o <= (v_q == gmax_q) || (cnt_q == 6'(MaxTicks - 1));
            v_q <= v_q + dd; cnt_q <= cnt_q + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ovalid_q;
endmodule

// ===== rtl/axis_tick_label_generator_core.sv =====
// Axis tick label generator: range items in, one transfer per tick out.
// Depends on atlg_pkg, atlg_front, atlg_back.
//
// Usage: write tick_count (address 0) over APB while idle; reset value 5.
// Each input transfer carries data_min/data_max (units of 1e-6). The block
// answers with one output transfer per tick from floor(min/d)*d up to
// ceil(max/d)*d, at most 62 ticks, is_last set on the final one; an empty
// range gives a single transfer with bad_range set.
// Each item takes three power-of-ten searches and three passes of one
// shared bit-serial divider (spacing, then the two grid ends) before its
// first tick; then one tick per cycle while the receiver takes them.
// The back part works on one item at a time. A two-entry queue lets the
// front accept items while the back is busy. A stalled output holds its
// payload; emission pauses.
// Reset clears queue, state and output valid.
module axis_tick_label_generator_core import atlg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  val_t        data_min_i,
  input  val_t        data_max_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [OutBits-1:0] tick_value_o,
  output uval_t       tick_spacing_o,
  output logic [2:0]  frac_digits_o,
  output logic        is_last_o,
  output logic        bad_range_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [5:0] tick_count_q;
  logic       job_valid, job_pop;
  job_t       job;

  assign pready = 1'b1;
  assign prdata = (paddr == RegTickCount) ? 32'(tick_count_q) : '0;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tick_count_q <= 6'd5;
    else if (psel && penable && pwrite && paddr == RegTickCount)
      tick_count_q <= pwdata[5:0];
  end

  atlg_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .data_min_i, .data_max_i,
    .tick_count_i(tick_count_q), .job_valid_o(job_valid), .job_o(job),
    .job_pop_i(job_pop)
  );

  atlg_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job), .job_pop_o(job_pop),
    .out_valid, .out_stall, .tick_value_o, .tick_spacing_o, .frac_digits_o,
    .is_last_o, .bad_range_o
  );
endmodule

// ===== rtl/atlg_checker.sv =====
// Port-level checker for the tick generator, bound to the top level.
// Depends on atlg_pkg.
module atlg_port_checker import atlg_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid,
  input logic out_stall,
  input logic is_last_o,
  input logic bad_range_o,
  input uval_t tick_spacing_o,
  input logic pready
);
  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(tick_spacing_o))
    else $error("stalled result changed");
  // an empty range is always a single final result
  a_bad_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && bad_range_o |-> is_last_o)
    else $error("bad range not last");
  // a real tick has nonzero spacing
  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !bad_range_o |-> tick_spacing_o != '0)
    else $error("zero spacing");
  a_ready: assert property (@(posedge clk_i) pready)
    else $error("pready low");
endmodule

bind axis_tick_label_generator_core atlg_port_checker u_chk (
  .clk_i, .rst_ni, .out_valid, .out_stall, .is_last_o, .bad_range_o,
  .tick_spacing_o, .pready
);
